// ===== design/sma_pkg.sv =====
// Shared widths and constants for the simple moving average block.
package sma_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int WIN_W      = 7;
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int TIME_W     = 48;
	localparam int PRICE_W    = 32;
	localparam int SUM_W      = PRICE_W + SLOT_W;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

	typedef logic        [TIME_W-1:0]  time_t;
	typedef logic signed [PRICE_W-1:0] price_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic        [WIN_W-1:0]   win_t;
	typedef logic        [SLOT_W-1:0]  slot_t;

endpackage

// ===== design/sma_if.sv =====
// Valid/ready channel interfaces for samples and averages.
interface sma_in_if;
	logic                 valid;
	logic                 ready;
	logic                 start_of_series;
	sma_pkg::time_t       sample_time;
	sma_pkg::price_t      close_price;

	modport source (output valid, output start_of_series, output sample_time,
		output close_price, input ready);
	modport sink (input valid, input start_of_series, input sample_time,
		input close_price, output ready);
endinterface

interface sma_out_if;
	logic                 valid;
	logic                 ready;
	sma_pkg::time_t       result_time;
	sma_pkg::price_t      average_price;

	modport source (output valid, output result_time, output average_price, input ready);
	modport sink (input valid, input result_time, input average_price, output ready);
endinterface

// ===== design/simple_moving_average.sv =====
// Simple moving average top level: ring memory, running sum, divider, output register.
// An item that completes a window: ring read, sum update and write-back, then the
// 38-step divider; result registered and next sample taken once the output is free.
// An item that gives no result: ring read, then sum update and write-back.
// Reset: window length 5, count, sum and write slot zero; ring contents undefined.
module simple_moving_average (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  sma_pkg::win_t     cfg_wdata,
	sma_in_if.sink            sample_ch,
	sma_out_if.source         result_ch
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0]            state_q;
	sma_pkg::win_t         window_q;
	sma_pkg::sum_t         sum_q;
	sma_pkg::win_t         seen_q;
	sma_pkg::slot_t        slot_q;

	sma_pkg::price_t       price_s1;
	sma_pkg::time_t        time_s1;
	sma_pkg::slot_t        slot_s1;
	sma_pkg::win_t         cnt_s1;
	sma_pkg::sum_t         sum_s1;

	logic                  out_valid_q;
	sma_pkg::time_t        out_time_q;
	sma_pkg::price_t       out_price_q;

	sma_pkg::win_t         n_eff;
	logic                  in_xfer;
	logic                  out_free;
	sma_pkg::slot_t        slot_sel;
	sma_pkg::price_t       old_price;
	sma_pkg::sum_t         new_sum;
	sma_pkg::win_t         new_cnt;
	sma_pkg::win_t         next_slot;
	logic                  div_start;
	logic                  div_busy;
	sma_pkg::price_t       div_quo;

	always_comb begin
		if (window_q == '0) begin
			n_eff = sma_pkg::win_t'(1);
		end else if (window_q > sma_pkg::win_t'(sma_pkg::MAX_WINDOW)) begin
			n_eff = sma_pkg::win_t'(sma_pkg::MAX_WINDOW);
		end else begin
			n_eff = window_q;
		end
	end

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign in_xfer         = sample_ch.valid && sample_ch.ready;
	assign out_free        = !out_valid_q || result_ch.ready;

	always_comb begin
		slot_sel = sample_ch.start_of_series ? '0 : slot_q;
		if ({1'b0, slot_sel} >= n_eff) begin
			slot_sel = '0;
		end
	end

	sma_ram #(
		.WIDTH(sma_pkg::PRICE_W),
		.DEPTH(sma_pkg::MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(slot_s1),
		.wdata(price_s1),
		.raddr(slot_sel),
		.rdata(old_price)
	);

	always_comb begin
		new_sum = sum_s1 + sma_pkg::sum_t'(price_s1);
		if (cnt_s1 >= n_eff) begin
			new_sum = new_sum - sma_pkg::sum_t'(old_price);
		end
		new_cnt   = (cnt_s1 < n_eff) ? cnt_s1 + 1'b1 : cnt_s1;
		next_slot = {1'b0, slot_s1} + 1'b1;
		if (next_slot >= n_eff) begin
			next_slot = '0;
		end
	end

	assign div_start = (state_q == ST_UPD) && (new_cnt >= n_eff);

	sma_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(new_sum),
		.divisor (n_eff),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			window_q <= sma_pkg::WINDOW_RESET;
			sum_q    <= '0;
			seen_q   <= '0;
			slot_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q   <= new_sum;
					seen_q  <= new_cnt;
					slot_q  <= next_slot[sma_pkg::SLOT_W-1:0];
					state_q <= div_start ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (!div_busy && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				window_q <= cfg_wdata;
				sum_q    <= '0;
				seen_q   <= '0;
				slot_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			price_s1 <= sample_ch.close_price;
			time_s1  <= sample_ch.sample_time;
			slot_s1  <= slot_sel;
			cnt_s1   <= sample_ch.start_of_series ? '0 : seen_q;
			sum_s1   <= sample_ch.start_of_series ? '0 : sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DIV && !div_busy && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && !div_busy && out_free) begin
			out_time_q  <= time_s1;
			out_price_q <= div_quo;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.result_time   = out_time_q;
	assign result_ch.average_price = out_price_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= n_eff)
		else $error("sample count exceeds window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < n_eff)
		else $error("write slot outside window");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !div_busy)
		else $error("sample transfer while divider busy");

endmodule

// ===== design/sma_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/sma_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sma_pkg::sum_t       dividend,
	input  sma_pkg::win_t       divisor,
	output logic                busy,
	output sma_pkg::price_t     quotient
);

	localparam int CNT_W = $clog2(sma_pkg::SUM_W);

	logic                          busy_q;
	logic                          neg_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [sma_pkg::SUM_W-1:0]     quo_q;
	logic [sma_pkg::WIN_W-1:0]     rem_q;
	logic [sma_pkg::WIN_W-1:0]     div_q;
	logic [sma_pkg::WIN_W:0]       trial;
	logic [sma_pkg::WIN_W:0]       diff;
	logic                          fits;
	logic [sma_pkg::SUM_W-1:0]     mag;
	logic [sma_pkg::SUM_W-1:0]     signed_quo;

	assign mag   = dividend[sma_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[sma_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(sma_pkg::SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[sma_pkg::SUM_W-1];
			quo_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sma_pkg::WIN_W-1:0] : trial[sma_pkg::WIN_W-1:0];
			quo_q <= {quo_q[sma_pkg::SUM_W-2:0], fits};
		end
	end

	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed_quo[sma_pkg::PRICE_W-1:0];
	assign busy       = busy_q;

endmodule
